// ===== src/svpwm_pkg.sv =====
// shared types and constants for the space vector pwm duty calculator
`default_nettype none

package svpwm_pkg;

    // q15 constants
    localparam logic [14:0] COS30_Q15  = 15'd28378;
    localparam logic [14:0] DUTY_MID   = 15'd16384;
    localparam logic [14:0] DUTY_MAX   = 15'd32767;
    localparam logic [14:0] ROUND_HALF = 15'd16384;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MIDPOINT = 1'b0,
        CFG_GAIN     = 1'b1
    } t_cfg_idx;

    // phase voltage, wide enough for inverse clarke and midpoint shift
    typedef logic signed [17:0] t_volt;

    typedef struct packed {
        t_volt a;
        t_volt b;
        t_volt c;
    } t_phases;

    typedef logic [14:0] t_duty;

    typedef struct packed {
        t_duty a;
        t_duty b;
        t_duty c;
    } t_duties;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } t_counts;

endpackage

`default_nettype wire

// ===== src/svpwm_clarke.sv =====
// two-stage inverse clarke transform
`default_nettype none

module svpwm_clarke (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    output logic                      o_rdy,
    input  wire logic signed [15:0]   i_alpha,
    input  wire logic signed [15:0]   i_beta,
    input  wire logic [15:0]          i_period,
    output logic                      o_vld,
    input  wire logic                 i_rdy,
    output svpwm_pkg::t_phases        o_phases,
    output logic [15:0]               o_period
);

    logic                r_vld1;
    logic                r_vld2;
    logic                n_en1;
    logic                n_en2;
    logic signed [15:0]  r_alpha;
    logic signed [31:0]  r_bprod;
    logic [15:0]         r_period1;
    logic signed [16:0]  n_h;
    logic signed [15:0]  n_q;
    svpwm_pkg::t_phases  n_phases;
    svpwm_pkg::t_phases  r_phases;
    logic [15:0]         r_period2;

    assign n_en2 = !r_vld2 || i_rdy;
    assign n_en1 = !r_vld1 || n_en2;
    assign o_rdy = n_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (n_en1) begin
                r_vld1 <= i_vld;
            end
            if (n_en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    // stage 1: beta times sqrt(3)/2
    always_ff @(posedge i_clk) begin
        if (n_en1 && i_vld) begin
            r_alpha   <= i_alpha;
            r_bprod   <= i_beta * $signed({1'b0, svpwm_pkg::COS30_Q15});
            r_period1 <= i_period;
        end
    end

    // stage 2: floor shifts and phase sums
    always_comb begin
        n_h        = $signed(r_bprod[31:15]);
        n_q        = r_alpha >>> 1;
        n_phases.a = 18'(r_alpha);
        n_phases.b = 18'(n_h) - 18'(n_q);
        n_phases.c = -18'(n_q) - 18'(n_h);
    end

    always_ff @(posedge i_clk) begin
        if (n_en2 && r_vld1) begin
            r_phases  <= n_phases;
            r_period2 <= r_period1;
        end
    end

    assign o_vld    = r_vld2;
    assign o_phases = r_phases;
    assign o_period = r_period2;

endmodule

`default_nettype wire

// ===== src/svpwm_midpoint.sv =====
// two-stage min/max midpoint injection
`default_nettype none

module svpwm_midpoint (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_mode,
    input  wire logic                 i_vld,
    output logic                      o_rdy,
    input  wire svpwm_pkg::t_phases   i_phases,
    input  wire logic [15:0]          i_period,
    output logic                      o_vld,
    input  wire logic                 i_rdy,
    output svpwm_pkg::t_phases        o_phases,
    output logic [15:0]               o_period
);

    logic                r_vld1;
    logic                r_vld2;
    logic                n_en1;
    logic                n_en2;
    svpwm_pkg::t_volt    n_mn;
    svpwm_pkg::t_volt    n_mx;
    logic signed [18:0]  n_sum;
    logic signed [18:0]  n_sumr;
    svpwm_pkg::t_volt    n_z;
    svpwm_pkg::t_volt    r_z;
    svpwm_pkg::t_phases  r_phases1;
    logic [15:0]         r_period1;
    svpwm_pkg::t_phases  r_phases2;
    logic [15:0]         r_period2;

    assign n_en2 = !r_vld2 || i_rdy;
    assign n_en1 = !r_vld1 || n_en2;
    assign o_rdy = n_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (n_en1) begin
                r_vld1 <= i_vld;
            end
            if (n_en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    // stage 1: midpoint, halved with truncation toward zero; zero when i_mode is low
    always_comb begin
        n_mn = i_phases.a;
        n_mx = i_phases.a;
        if (i_phases.b < n_mn) begin
            n_mn = i_phases.b;
        end
        if (i_phases.c < n_mn) begin
            n_mn = i_phases.c;
        end
        if (i_phases.b > n_mx) begin
            n_mx = i_phases.b;
        end
        if (i_phases.c > n_mx) begin
            n_mx = i_phases.c;
        end
        n_sum  = 19'(n_mn) + 19'(n_mx);
        n_sumr = n_sum + $signed({18'd0, n_sum[18]});
        n_z    = i_mode ? 18'(n_sumr >>> 1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (n_en1 && i_vld) begin
            r_z       <= n_z;
            r_phases1 <= i_phases;
            r_period1 <= i_period;
        end
    end

    // stage 2: shift every phase by the midpoint
    always_ff @(posedge i_clk) begin
        if (n_en2 && r_vld1) begin
            r_phases2.a <= r_phases1.a - r_z;
            r_phases2.b <= r_phases1.b - r_z;
            r_phases2.c <= r_phases1.c - r_z;
            r_period2   <= r_period1;
        end
    end

    assign o_vld    = r_vld2;
    assign o_phases = r_phases2;
    assign o_period = r_period2;

endmodule

`default_nettype wire

// ===== src/svpwm_duty.sv =====
// two-stage gain multiply, half offset and clamp
`default_nettype none

module svpwm_duty (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [15:0]          i_gain,
    input  wire logic                 i_vld,
    output logic                      o_rdy,
    input  wire svpwm_pkg::t_phases   i_phases,
    input  wire logic [15:0]          i_period,
    output logic                      o_vld,
    input  wire logic                 i_rdy,
    output svpwm_pkg::t_duties        o_duties,
    output logic [15:0]               o_period
);

    logic                r_vld1;
    logic                r_vld2;
    logic                n_en1;
    logic                n_en2;
    logic signed [16:0]  n_gain;
    logic signed [34:0]  r_prod_a;
    logic signed [34:0]  r_prod_b;
    logic signed [34:0]  r_prod_c;
    logic [15:0]         r_period1;
    svpwm_pkg::t_duties  r_duties;
    logic [15:0]         r_period2;

    function automatic svpwm_pkg::t_duty clamp_duty(input logic signed [34:0] p);
        logic signed [35:0] d;
        d = 36'(p) + $signed({21'd0, svpwm_pkg::DUTY_MID});
        if (d < 0) begin
            return '0;
        end else if (d > $signed({21'd0, svpwm_pkg::DUTY_MAX})) begin
            return svpwm_pkg::DUTY_MAX;
        end else begin
            return d[14:0];
        end
    endfunction

    assign n_en2  = !r_vld2 || i_rdy;
    assign n_en1  = !r_vld1 || n_en2;
    assign o_rdy  = n_en1;
    assign n_gain = $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (n_en1) begin
                r_vld1 <= i_vld;
            end
            if (n_en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    // stage 1: one multiplier per phase
    always_ff @(posedge i_clk) begin
        if (n_en1 && i_vld) begin
            r_prod_a  <= i_phases.a * n_gain;
            r_prod_b  <= i_phases.b * n_gain;
            r_prod_c  <= i_phases.c * n_gain;
            r_period1 <= i_period;
        end
    end

    // stage 2: offset and saturate
    always_ff @(posedge i_clk) begin
        if (n_en2 && r_vld1) begin
            r_duties.a <= clamp_duty(r_prod_a);
            r_duties.b <= clamp_duty(r_prod_b);
            r_duties.c <= clamp_duty(r_prod_c);
            r_period2  <= r_period1;
        end
    end

    assign o_vld    = r_vld2;
    assign o_duties = r_duties;
    assign o_period = r_period2;

endmodule

`default_nettype wire

// ===== src/svpwm_count.sv =====
// two-stage period scaling with round half up
`default_nettype none

module svpwm_count (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    output logic                      o_rdy,
    input  wire svpwm_pkg::t_duties   i_duties,
    input  wire logic [15:0]          i_period,
    output logic                      o_vld,
    input  wire logic                 i_rdy,
    output svpwm_pkg::t_duties        o_duties,
    output svpwm_pkg::t_counts        o_counts
);

    logic                r_vld1;
    logic                r_vld2;
    logic                n_en1;
    logic                n_en2;
    logic [30:0]         r_cprod_a;
    logic [30:0]         r_cprod_b;
    logic [30:0]         r_cprod_c;
    svpwm_pkg::t_duties  r_duties1;
    logic [31:0]         n_sum_a;
    logic [31:0]         n_sum_b;
    logic [31:0]         n_sum_c;
    svpwm_pkg::t_duties  r_duties2;
    svpwm_pkg::t_counts  r_counts;

    assign n_en2 = !r_vld2 || i_rdy;
    assign n_en1 = !r_vld1 || n_en2;
    assign o_rdy = n_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (n_en1) begin
                r_vld1 <= i_vld;
            end
            if (n_en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    // stage 1: period times duty
    always_ff @(posedge i_clk) begin
        if (n_en1 && i_vld) begin
            r_cprod_a <= i_period * i_duties.a;
            r_cprod_b <= i_period * i_duties.b;
            r_cprod_c <= i_period * i_duties.c;
            r_duties1 <= i_duties;
        end
    end

    // stage 2: round half up, back to timer counts
    always_comb begin
        n_sum_a = 32'(r_cprod_a) + 32'(svpwm_pkg::ROUND_HALF);
        n_sum_b = 32'(r_cprod_b) + 32'(svpwm_pkg::ROUND_HALF);
        n_sum_c = 32'(r_cprod_c) + 32'(svpwm_pkg::ROUND_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (n_en2 && r_vld1) begin
            r_counts.a <= n_sum_a[30:15];
            r_counts.b <= n_sum_b[30:15];
            r_counts.c <= n_sum_c[30:15];
            r_duties2  <= r_duties1;
        end
    end

    assign o_vld    = r_vld2;
    assign o_duties = r_duties2;
    assign o_counts = r_counts;

endmodule

`default_nettype wire

// ===== src/svpwm_duty_calculator.sv =====
// space vector pwm duty calculator top level
// throughput: one vector per cycle while m_axis_tready is high, set by the
//   eight-stage pipeline in which every stage can take a new beat each cycle;
//   every stage holds its own valid bit
// stalls: a stage loads whenever it is empty or its successor moves, so bubbles
//   collapse and input is taken while a finished beat waits at the output
// reset: i_rst_n low clears all valid bits, midpoint mode to 0 and gain to 1
`default_nettype none

module svpwm_duty_calculator (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write port
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] alpha_voltage, [31:16] beta_voltage, [47:32] carrier_period
    input  wire logic [47:0]  s_axis_tdata,
    // output stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [14:0] duty_a, [29:15] duty_b, [44:30] duty_c, [60:45] count_a,
    // [76:61] count_b, [92:77] count_c, [95:93] zero
    output logic [95:0]       m_axis_tdata
);

    // configuration registers
    logic         r_mode;
    logic [15:0]  r_gain;

    // stage handshakes between sections
    logic                clk_vld;
    logic                mid_rdy;
    logic                mid_vld;
    logic                dty_rdy;
    logic                dty_vld;
    logic                cnt_rdy;

    svpwm_pkg::t_phases  clk_phases;
    logic [15:0]         clk_period;
    svpwm_pkg::t_phases  mid_phases;
    logic [15:0]         mid_period;
    svpwm_pkg::t_duties  dty_duties;
    logic [15:0]         dty_period;
    svpwm_pkg::t_duties  out_duties;
    svpwm_pkg::t_counts  out_counts;

    // register writes; both index values are listed, so the default arm is never taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_gain <= 16'd1;
        end else if (i_cfg_we) begin
            case (svpwm_pkg::t_cfg_idx'(i_cfg_idx))
                svpwm_pkg::CFG_MIDPOINT: begin
                    r_mode <= i_cfg_data[0];
                end
                svpwm_pkg::CFG_GAIN: begin
                    r_gain <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // stages 1-2: beta scaling, then phase voltages
    svpwm_clarke u_clarke (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (s_axis_tvalid),
        .o_rdy    (s_axis_tready),
        .i_alpha  ($signed(s_axis_tdata[15:0])),
        .i_beta   ($signed(s_axis_tdata[31:16])),
        .i_period (s_axis_tdata[47:32]),
        .o_vld    (clk_vld),
        .i_rdy    (mid_rdy),
        .o_phases (clk_phases),
        .o_period (clk_period)
    );

    // stages 3-4: zero-sequence offset from min and max phase
    svpwm_midpoint u_midpoint (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_vld    (clk_vld),
        .o_rdy    (mid_rdy),
        .i_phases (clk_phases),
        .i_period (clk_period),
        .o_vld    (mid_vld),
        .i_rdy    (dty_rdy),
        .o_phases (mid_phases),
        .o_period (mid_period)
    );

    // stages 5-6: gain product, half offset, saturation to q15
    svpwm_duty u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gain   (r_gain),
        .i_vld    (mid_vld),
        .o_rdy    (dty_rdy),
        .i_phases (mid_phases),
        .i_period (mid_period),
        .o_vld    (dty_vld),
        .i_rdy    (cnt_rdy),
        .o_duties (dty_duties),
        .o_period (dty_period)
    );

    // stages 7-8: compare counts; stage 8 is the output register
    svpwm_count u_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (dty_vld),
        .o_rdy    (cnt_rdy),
        .i_duties (dty_duties),
        .i_period (dty_period),
        .o_vld    (m_axis_tvalid),
        .i_rdy    (m_axis_tready),
        .o_duties (out_duties),
        .o_counts (out_counts)
    );

    assign m_axis_tdata = {3'b000,
                           out_counts.c, out_counts.b, out_counts.a,
                           out_duties.c, out_duties.b, out_duties.a};

    // a free output side must let every stage move, so input is never refused
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input refused while output side is free");

    // reset empties the pipeline
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // zero gain leaves every phase at half duty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_gain == 16'd0) |->
        (out_duties.a == svpwm_pkg::DUTY_MID && out_duties.b == svpwm_pkg::DUTY_MID
         && out_duties.c == svpwm_pkg::DUTY_MID))
        else $error("zero gain gave a duty other than half");

    // a zero duty on phase a must give a zero compare count on phase a
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_duties.a == '0) |-> out_counts.a == '0)
        else $error("nonzero count for zero duty");

endmodule

`default_nettype wire

// ===== test/svpwm_duty_checker.sv =====
// checker for the duty calculator: watches both streams, predicts and compares beats
module svpwm_duty_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [95:0] i_m_axis_tdata,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0][15:0] count;
        logic [2:0][14:0] duty;
    } t_phase_set;

    t_phase_set  duties_due[$];
    logic        midpoint_on;
    logic [15:0] link_gain;
    int          out_beats;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        out_beats    = 0;
        midpoint_on  = 1'b0;
        link_gain    = 16'd1;
    end

    task automatic report_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 40) begin
            $display("[%0t] output beat %0d: %s", $realtime, out_beats, msg);
        end
    endtask

    // inverse clarke, optional min/max injection, gain, clamp and period scaling
    function automatic t_phase_set calc_duties(input logic [47:0] vec);
        longint     alpha;
        longint     beta;
        longint     half_term;
        longint     sin_term;
        longint     lo;
        longint     hi;
        longint     zero_seq;
        longint     d;
        longint     volt [3];
        t_phase_set res;
        alpha     = longint'($signed(vec[15:0]));
        beta      = longint'($signed(vec[31:16]));
        sin_term  = (beta * longint'(svpwm_pkg::COS30_Q15)) >>> 15;
        half_term = alpha >>> 1;
        volt[0]   = alpha;
        volt[1]   = sin_term - half_term;
        volt[2]   = -half_term - sin_term;
        if (midpoint_on) begin
            lo = volt[0];
            hi = volt[0];
            for (int i = 1; i < 3; i++) begin
                if (volt[i] < lo) lo = volt[i];
                if (volt[i] > hi) hi = volt[i];
            end
            // signed divide truncates toward zero
            zero_seq = (lo + hi) / 2;
            for (int i = 0; i < 3; i++) volt[i] -= zero_seq;
        end
        for (int i = 0; i < 3; i++) begin
            d = longint'(svpwm_pkg::DUTY_MID) + volt[i] * longint'(link_gain);
            if (d < 0) d = 0;
            if (d > longint'(svpwm_pkg::DUTY_MAX)) d = longint'(svpwm_pkg::DUTY_MAX);
            res.duty[i]  = d[14:0];
            res.count[i] = 16'((longint'(vec[47:32]) * d
                                + longint'(svpwm_pkg::ROUND_HALF)) >>> 15);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_phase_set got;
        t_phase_set want;
        if (!i_rst_n) begin
            duties_due.delete();
            midpoint_on = 1'b0;
            link_gain   = 16'd1;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                for (int i = 0; i < 3; i++) begin
                    got.duty[i]  = i_m_axis_tdata[15*i +: 15];
                    got.count[i] = i_m_axis_tdata[45 + 16*i +: 16];
                end
                if (duties_due.size() == 0) begin
                    report_failure("beat with no expectation waiting");
                end else begin
                    want = duties_due.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (got.duty[i] !== want.duty[i])
                            report_failure($sformatf("duty of phase %0d expected %0d got %0d",
                                                     i, want.duty[i], got.duty[i]));
                        if (got.count[i] !== want.count[i])
                            report_failure($sformatf("count of phase %0d expected %0d got %0d",
                                                     i, want.count[i], got.count[i]));
                    end
                end
                out_beats++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                duties_due.push_back(calc_duties(i_s_axis_tdata));
            end
            if (i_cfg_we) begin
                case (svpwm_pkg::t_cfg_idx'(i_cfg_idx))
                    svpwm_pkg::CFG_MIDPOINT: midpoint_on = i_cfg_data[0];
                    svpwm_pkg::CFG_GAIN:     link_gain   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = duties_due.size();
    end

endmodule

// ===== test/testbench.sv =====
// top of the duty calculator testbench: stimulus, idling, config phases and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [15:0] alpha_voltage, [31:16] beta_voltage, [47:32] carrier_period
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [14:0] duty_a, [29:15] duty_b, [44:30] duty_c, [60:45] count_a,
    // [76:61] count_b, [92:77] count_c, [95:93] zero
    logic [95:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    // no_idle: both sides run back to back; hold_req: receiver takes a long break
    bit          no_idle  = 1'b0;
    bit          hold_req = 1'b0;
    logic [15:0] cur_gain = 16'd1;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    svpwm_duty_calculator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    svpwm_duty_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // offer one vector after a random gap; returns on the falling edge after
    // the beat was taken, with tvalid still high so a back-to-back beat can follow
    task automatic send_vector(input logic [15:0] alpha, input logic [15:0] beta,
                               input logic [15:0] period);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {period, beta, alpha};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // drop tvalid and wait until every beat in flight has come out
    task automatic drain_pipeline();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        // then idle on as a margin
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input svpwm_pkg::t_cfg_idx idx, input logic [15:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // mode_word may carry junk in its upper bits, only bit 0 should stick
    task automatic configure(input logic [15:0] mode_word, input logic [15:0] gain);
        drain_pipeline();
        write_reg(svpwm_pkg::CFG_MIDPOINT, mode_word);
        write_reg(svpwm_pkg::CFG_GAIN, gain);
        cur_gain = gain;
    endtask

    function automatic logic [15:0] pick_edge();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            5:       return 16'h7FFE;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(2, 8));
            4:       return 16'($urandom_range(9, 300));
            default: return 16'($urandom());
        endcase
    endfunction

    // signed value within +-lim
    function automatic logic [15:0] pick_volt(input int lim);
        return 16'(int'($urandom_range(0, 2 * lim)) - lim);
    endfunction

    // corners of the vector space and of the period
    task automatic send_corner_set();
        send_vector(16'h0000, 16'h0000, 16'd0);
        send_vector(16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_vector(16'h8000, 16'h8000, 16'hFFFF);
        send_vector(16'h7FFF, 16'h8000, 16'd1);
        send_vector(16'h8000, 16'h7FFF, 16'd0);
    endtask

    // random vectors, mostly sized so the gain leaves the duty unsaturated
    task automatic send_random_vectors(input int count);
        int          lim;
        logic [15:0] alpha;
        logic [15:0] beta;
        logic [15:0] period;
        lim = (cur_gain <= 16'd1) ? 32767 : 24000 / int'(cur_gain) + 1;
        repeat (count) begin
            case ($urandom_range(0, 5))
                0: begin
                    alpha = 16'($urandom());
                    beta  = 16'($urandom());
                end
                1: begin
                    alpha = pick_edge();
                    beta  = pick_edge();
                end
                default: begin
                    alpha = pick_volt(lim);
                    beta  = pick_volt(lim);
                end
            endcase
            case ($urandom_range(0, 9))
                0:       period = 16'd0;
                1:       period = 16'hFFFF;
                default: period = 16'($urandom());
            endcase
            send_vector(alpha, beta, period);
        end
    endtask

    // receiver: random stall per beat, a long hold when asked for
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (hold_req) begin
                // long hold-off so the pipeline fills and backs up the input
                m_axis_tready = 1'b0;
                repeat (240) @(negedge i_clk);
                hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // main stimulus
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = svpwm_pkg::CFG_MIDPOINT;
        i_cfg_data    = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 48'd0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: no injection, unit gain
        send_corner_set();
        // zero gain, midpoint set through a word full of ones
        configure(16'hFFFF, 16'd0);
        send_corner_set();
        // largest gain with injection
        configure(16'h0001, 16'hFFFF);
        send_corner_set();
        // junk upper bits with bit 0 clear leave injection off
        configure(16'hFFFE, 16'd2);
        send_corner_set();

        // random phases, each with its own setting
        for (int ph = 0; ph < 8; ph++) begin
            configure({15'($urandom()), 1'($urandom_range(0, 1))}, pick_gain());
            if (ph == 3) begin
                no_idle  = 1'b1;
                hold_req = 1'b1;
            end
            if (ph == 5) no_idle = 1'b1;
            send_random_vectors(88);
            no_idle = 1'b0;
        end

        drain_pipeline();
        repeat (16) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
